// ----- design/ilirs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilirs_pkg
// Types, codes and helpers for the indexed list with insert, remove and sort.
// ----------------------------------------------------------------------------
package ilirs_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int POS_W       = 6;
  localparam int CNT_W       = 7;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [POS_W-1:0]              pos_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;
  localparam logic [2:0] OP_SORT   = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_POS   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

  typedef struct packed {
    logic [2:0] op;
    pos_t       position;
    value_t     value;
  } in_item_t;

  typedef struct packed {
    value_t     read_value;
    pos_t       found_position;
    cnt_t       entry_count;
    logic [1:0] status;
  } out_item_t;

  // true when a belongs in front of b for the selected order
  function automatic logic goes_before(input value_t a, input value_t b, input logic desc);
    logic r;
    r = desc ? (a > b) : (a < b);
    return r;
  endfunction

endpackage

// ----- design/indexed_list_insert_remove_sort_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_sort_top
// Ordered list of up to 64 signed values with append, insert, remove, read,
// find, clear and selection sort, one result per transaction.
// ----------------------------------------------------------------------------
// The list lives in a 64 x 32 memory with one write port and one registered
// read port, walked by a small sequencer; one transaction is handled at a
// time and in_ready is high only while the sequencer waits for work. Every
// element visit reads the memory, then uses the registered data: insert and
// remove move one entry per visit, find compares one entry per visit until a
// match, and sort scans for the best entry from each position and swaps it
// in with two writes when it lies elsewhere. Append, clear, the unused op and
// any transaction refused by a check need no visit. Any result may also wait for out_ready.
// A new transaction is taken while the previous result still waits on the
// output register. The sort order register takes a write only while the
// sequencer is idle. No clearing pass runs after reset.
module indexed_list_insert_remove_sort_top import ilirs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_INS_RD     = 4'd1;
  localparam logic [3:0] S_INS_WR     = 4'd2;
  localparam logic [3:0] S_REM_RD     = 4'd3;
  localparam logic [3:0] S_REM_WR     = 4'd4;
  localparam logic [3:0] S_RD_WAIT    = 4'd5;
  localparam logic [3:0] S_FIND_RD    = 4'd6;
  localparam logic [3:0] S_FIND_CMP   = 4'd7;
  localparam logic [3:0] S_SORT_I     = 4'd8;
  localparam logic [3:0] S_SORT_ILD   = 4'd9;
  localparam logic [3:0] S_SORT_JRD   = 4'd10;
  localparam logic [3:0] S_SORT_JCMP  = 4'd11;
  localparam logic [3:0] S_SORT_SWAP  = 4'd12;
  localparam logic [3:0] S_SORT_SWAP2 = 4'd13;
  localparam logic [3:0] S_FIN        = 4'd14;

  value_t mem [DEPTH];
  value_t mem_q;
  logic   mem_we;
  pos_t   mem_wa;
  value_t mem_wd;
  pos_t   mem_ra;

  logic [3:0] state, state_next;
  cnt_t       count, count_next;
  cnt_t       idx, idx_next;
  cnt_t       jdx, jdx_next;
  pos_t       best, best_next;
  value_t     best_val, best_val_next;
  value_t     i_val, i_val_next;
  in_item_t   cmd, cmd_next;
  value_t     rd_val, rd_val_next;
  pos_t       fpos, fpos_next;
  logic [1:0] status, status_next;
  logic       out_valid_next;
  out_item_t  out_data_next;
  logic       sort_descending;
  cnt_t       in_pos;
  cnt_t       cmd_pos;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_pos    = {1'b0, in_data.position};
  assign cmd_pos   = {1'b0, cmd.position};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    jdx_next       = jdx;
    best_next      = best;
    best_val_next  = best_val;
    i_val_next     = i_val;
    cmd_next       = cmd;
    rd_val_next    = rd_val;
    fpos_next      = fpos;
    status_next    = status;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_ra         = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_next    = in_data;
          rd_val_next = '0;
          fpos_next   = '0;
          status_next = ST_OK;
          state_next  = S_FIN;
          unique case (in_data.op)
            OP_APPEND: begin
              if (count == DEPTH_CNT) begin
                status_next = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_wa     = count[POS_W-1:0];
                mem_wd     = in_data.value;
                count_next = cnt_t'(count + cnt_t'(1));
              end
            end
            OP_INSERT: begin
              if (count == DEPTH_CNT) begin
                status_next = ST_FULL;
              end else if (in_pos > count) begin
                status_next = ST_BAD_POS;
              end else begin
                idx_next   = count;
                state_next = S_INS_RD;
              end
            end
            OP_REMOVE: begin
              if (in_pos >= count) begin
                status_next = ST_BAD_POS;
              end else begin
                idx_next   = in_pos;
                state_next = S_REM_RD;
              end
            end
            OP_READ: begin
              if (in_pos >= count) begin
                status_next = ST_BAD_POS;
              end else begin
                mem_ra     = in_data.position;
                state_next = S_RD_WAIT;
              end
            end
            OP_FIND: begin
              status_next = ST_NOT_FOUND;
              idx_next    = '0;
              state_next  = S_FIND_RD;
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_SORT: begin
              idx_next   = '0;
              state_next = S_SORT_I;
            end
            default: begin
            end
          endcase
        end
      end
      // shift up from the top, then drop the new value in
      S_INS_RD: begin
        if (idx > cmd_pos) begin
          mem_ra     = pos_t'(idx - cnt_t'(1));
          state_next = S_INS_WR;
        end else begin
          mem_we     = 1'b1;
          mem_wa     = cmd.position;
          mem_wd     = cmd.value;
          count_next = cnt_t'(count + cnt_t'(1));
          state_next = S_FIN;
        end
      end
      S_INS_WR: begin
        mem_we     = 1'b1;
        mem_wa     = idx[POS_W-1:0];
        mem_wd     = mem_q;
        idx_next   = cnt_t'(idx - cnt_t'(1));
        state_next = S_INS_RD;
      end
      S_REM_RD: begin
        if (cnt_t'(idx + cnt_t'(1)) < count) begin
          mem_ra     = pos_t'(idx + cnt_t'(1));
          state_next = S_REM_WR;
        end else begin
          count_next = cnt_t'(count - cnt_t'(1));
          state_next = S_FIN;
        end
      end
      S_REM_WR: begin
        mem_we     = 1'b1;
        mem_wa     = idx[POS_W-1:0];
        mem_wd     = mem_q;
        idx_next   = cnt_t'(idx + cnt_t'(1));
        state_next = S_REM_RD;
      end
      S_RD_WAIT: begin
        rd_val_next = mem_q;
        state_next  = S_FIN;
      end
      S_FIND_RD: begin
        if (idx < count) begin
          mem_ra     = idx[POS_W-1:0];
          state_next = S_FIND_CMP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIND_CMP: begin
        if (mem_q == cmd.value) begin
          fpos_next   = idx[POS_W-1:0];
          status_next = ST_OK;
          state_next  = S_FIN;
        end else begin
          idx_next   = cnt_t'(idx + cnt_t'(1));
          state_next = S_FIND_RD;
        end
      end
      // selection sort: scan for the best from idx up, then swap it into idx
      S_SORT_I: begin
        if (cnt_t'(idx + cnt_t'(1)) < count) begin
          mem_ra     = idx[POS_W-1:0];
          state_next = S_SORT_ILD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SORT_ILD: begin
        best_next     = idx[POS_W-1:0];
        best_val_next = mem_q;
        i_val_next    = mem_q;
        jdx_next      = cnt_t'(idx + cnt_t'(1));
        state_next    = S_SORT_JRD;
      end
      S_SORT_JRD: begin
        if (jdx < count) begin
          mem_ra     = jdx[POS_W-1:0];
          state_next = S_SORT_JCMP;
        end else begin
          state_next = S_SORT_SWAP;
        end
      end
      S_SORT_JCMP: begin
        if (goes_before(mem_q, best_val, sort_descending)) begin
          best_next     = jdx[POS_W-1:0];
          best_val_next = mem_q;
        end
        jdx_next   = cnt_t'(jdx + cnt_t'(1));
        state_next = S_SORT_JRD;
      end
      S_SORT_SWAP: begin
        if (best != idx[POS_W-1:0]) begin
          mem_we     = 1'b1;
          mem_wa     = idx[POS_W-1:0];
          mem_wd     = best_val;
          state_next = S_SORT_SWAP2;
        end else begin
          idx_next   = cnt_t'(idx + cnt_t'(1));
          state_next = S_SORT_I;
        end
      end
      S_SORT_SWAP2: begin
        mem_we     = 1'b1;
        mem_wa     = best;
        mem_wd     = i_val;
        idx_next   = cnt_t'(idx + cnt_t'(1));
        state_next = S_SORT_I;
      end
      S_FIN: begin
        // hold here until the output register is free
        if (!out_valid || out_ready) begin
          out_data_next  = '{read_value: rd_val, found_position: fpos,
                             entry_count: count, status: status};
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      count           <= '0;
      out_valid       <= 1'b0;
      sort_descending <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        sort_descending <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    jdx      <= jdx_next;
    best     <= best_next;
    best_val <= best_val_next;
    i_val    <= i_val_next;
    cmd      <= cmd_next;
    rd_val   <= rd_val_next;
    fpos     <= fpos_next;
    status   <= status_next;
    out_data <= out_data_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("entry count above depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while busy");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.op == OP_CLEAR) |=> (count == '0))
    else $error("clear left entries");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.entry_count == DEPTH_CNT))
    else $error("full status with room left");

endmodule

// ----- dv/tb_indexed_list_insert_remove_sort_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove_sort_top
// Self-checking bench for the indexed list. A short table of directed
// transactions covers an empty list, out-of-range positions, failed
// and duplicate finds, the unused op and an ascending sort. Phases of random
// transactions follow, each under its own sort order and op mix, so the
// list fills, churns and drains. Every result is checked against the table
// or a local model, with random gaps on both handshakes outside quiet phases.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_remove_sort_top;
  import ilirs_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 235;
  localparam int SETTLE_CYCLES = 20;

  typedef enum logic [1:0] {MIX_GROW, MIX_CHURN, MIX_SHRINK} op_mix_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } step_row_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  // local copy of the list
  value_t      list_mem [DEPTH];
  int unsigned list_len = 0;
  logic        desc_order = 1'b0;

  out_item_t   pending_results [$];
  int unsigned fail_count = 0;
  int unsigned rx_hold = 0;
  bit          no_gaps = 1'b0;
  step_row_t   directed_rows [$];

  indexed_list_insert_remove_sort_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // applies one transaction to the local list and returns its result
  function automatic out_item_t list_step(in_item_t it);
    out_item_t   r;
    int unsigned i;
    int unsigned j;
    int unsigned best;
    value_t      t;
    r = '0;
    case (it.op)
      OP_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = it.value;
          list_len++;
        end
      end
      OP_INSERT: begin
        // full check wins over the position check
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (it.position > list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          for (i = list_len; i > it.position; i--) begin
            list_mem[i] = list_mem[i-1];
          end
          list_mem[it.position] = it.value;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (it.position >= list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          for (i = it.position; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i+1];
          end
          list_len--;
        end
      end
      OP_READ: begin
        if (it.position >= list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          r.read_value = list_mem[it.position];
        end
      end
      OP_FIND: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == it.value) begin
            r.found_position = pos_t'(i);
            r.status = ST_OK;
            break;
          end
        end
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      OP_SORT: begin
        for (i = 0; i + 1 < list_len; i++) begin
          best = i;
          for (j = i + 1; j < list_len; j++) begin
            if (desc_order ? (list_mem[j] > list_mem[best]) :
                             (list_mem[j] < list_mem[best])) begin
              best = j;
            end
          end
          if (best != i) begin
            t = list_mem[i];
            list_mem[i] = list_mem[best];
            list_mem[best] = t;
          end
        end
      end
      default: begin
      end
    endcase
    r.entry_count = cnt_t'(list_len);
    return r;
  endfunction

  function automatic step_row_t row(logic [2:0] op, int unsigned pos, value_t val);
    step_row_t s;
    s.item = '{op: op, position: pos_t'(pos), value: val};
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_row_t row_chk(logic [2:0] op, int unsigned pos, value_t val,
                                        value_t rd, int unsigned fp, int unsigned cnt,
                                        logic [1:0] st);
    step_row_t s;
    s = row(op, pos, val);
    s.typed = 1'b1;
    s.want = '{read_value: rd, found_position: pos_t'(fp), entry_count: cnt_t'(cnt),
               status: st};
    return s;
  endfunction

  // random transaction, weighted toward positions and values that hit entries
  function automatic in_item_t pick_item(op_mix_t mix);
    int unsigned w [8];
    int unsigned r;
    int unsigned acc;
    int unsigned k;
    int unsigned p;
    in_item_t    it;
    case (mix)
      MIX_GROW:  w = '{30, 25, 10, 12, 18, 0, 3, 2};
      MIX_CHURN: w = '{15, 18, 32, 13, 15, 2, 3, 2};
      default:   w = '{6, 8, 46, 15, 17, 2, 4, 2};
    endcase
    r = $urandom_range(0, 99);
    acc = 0;
    it.op = OP_UNUSED;
    for (k = 0; k < 8; k++) begin
      acc += w[k];
      if (r < acc) begin
        it.op = 3'(k);
        break;
      end
    end

    r = $urandom_range(0, 99);
    if (r < 65) begin
      if (it.op == OP_INSERT) begin
        p = $urandom_range(0, list_len);
      end else if (it.op == OP_REMOVE || it.op == OP_READ) begin
        p = (list_len != 0) ? $urandom_range(0, list_len - 1) : 0;
      end else begin
        p = $urandom_range(0, 63);
      end
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       p = list_len;
        1:       p = (list_len != 0) ? list_len - 1 : 0;
        2:       p = 0;
        default: p = 63;
      endcase
    end else begin
      p = $urandom_range(0, 63);
    end
    it.position = pos_t'((p > 63) ? 63 : p);

    r = $urandom_range(0, 99);
    if (r < 30) begin
      // narrow pool so finds hit duplicates
      it.value = value_t'(int'($urandom_range(0, 8)) - 4);
    end else if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       it.value = value_t'(32'h8000_0000);
        1:       it.value = value_t'(32'h7fff_ffff);
        2:       it.value = '0;
        default: it.value = '1;
      endcase
    end else if (r < 65 && list_len != 0) begin
      it.value = list_mem[$urandom_range(0, list_len - 1)];
    end else begin
      it.value = value_t'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int unsigned n;
    out_item_t   predicted;
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predicted = list_step(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_sort_order(logic d);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    desc_order = d;
    cfg_valid <= 1'b0;
  endtask

  // result side: random backpressure and checking
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: rd=%0d fp=%0d cnt=%0d st=%0d",
                     out_data.read_value, out_data.found_position,
                     out_data.entry_count, out_data.status);
          end
        end else begin
          if (out_data.read_value !== pending_results[0].read_value ||
              out_data.found_position !== pending_results[0].found_position ||
              out_data.entry_count !== pending_results[0].entry_count ||
              out_data.status !== pending_results[0].status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp rd=%0d fp=%0d cnt=%0d st=%0d,",
                       pending_results[0].read_value, pending_results[0].found_position,
                       pending_results[0].entry_count, pending_results[0].status,
                       " got rd=%0d fp=%0d cnt=%0d st=%0d",
                       out_data.read_value, out_data.found_position,
                       out_data.entry_count, out_data.status);
            end
          end
          void'(pending_results.pop_front());
        end
      end
      if (rx_hold != 0) begin
        out_ready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) begin
          rx_hold <= gap_len();
        end
      end
    end
  end

  initial begin
    op_mix_t     phase_mix [PHASES];
    logic        phase_desc [PHASES];
    bit          phase_quiet [PHASES];
    int unsigned ph;
    int unsigned k;
    value_t      vmin;
    value_t      vmax;
    vmin = value_t'(32'h8000_0000);
    vmax = value_t'(32'h7fff_ffff);
    phase_mix = '{MIX_GROW, MIX_GROW, MIX_CHURN, MIX_SHRINK,
                  MIX_GROW, MIX_CHURN, MIX_SHRINK, MIX_CHURN};
    phase_desc = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_quiet = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    // empty list
    directed_rows.push_back(row_chk(OP_READ, 0, 0, 0, 0, 0, ST_BAD_POS));
    directed_rows.push_back(row_chk(OP_REMOVE, 0, 0, 0, 0, 0, ST_BAD_POS));
    directed_rows.push_back(row_chk(OP_FIND, 0, 5, 0, 0, 0, ST_NOT_FOUND));
    directed_rows.push_back(row_chk(OP_SORT, 0, 0, 0, 0, 0, ST_OK));
    directed_rows.push_back(row_chk(OP_UNUSED, 63, '1, 0, 0, 0, ST_OK));
    // build 0, min, max, -1 through appends and inserts
    directed_rows.push_back(row_chk(OP_APPEND, 0, vmin, 0, 0, 1, ST_OK));
    directed_rows.push_back(row_chk(OP_APPEND, 63, vmax, 0, 0, 2, ST_OK));
    directed_rows.push_back(row_chk(OP_INSERT, 3, 9, 0, 0, 2, ST_BAD_POS));
    directed_rows.push_back(row_chk(OP_INSERT, 2, -1, 0, 0, 3, ST_OK));
    directed_rows.push_back(row_chk(OP_INSERT, 0, 0, 0, 0, 4, ST_OK));
    directed_rows.push_back(row_chk(OP_READ, 0, 0, 0, 0, 4, ST_OK));
    directed_rows.push_back(row_chk(OP_READ, 1, 0, vmin, 0, 4, ST_OK));
    directed_rows.push_back(row_chk(OP_READ, 63, 0, 0, 0, 4, ST_BAD_POS));
    directed_rows.push_back(row_chk(OP_FIND, 0, vmax, 0, 2, 4, ST_OK));
    directed_rows.push_back(row_chk(OP_FIND, 0, -1, 0, 3, 4, ST_OK));
    directed_rows.push_back(row_chk(OP_FIND, 0, 12345, 0, 0, 4, ST_NOT_FOUND));
    directed_rows.push_back(row(OP_SORT, 0, 0));
    directed_rows.push_back(row_chk(OP_READ, 0, 0, vmin, 0, 4, ST_OK));
    directed_rows.push_back(row_chk(OP_READ, 3, 0, vmax, 0, 4, ST_OK));
    directed_rows.push_back(row(OP_REMOVE, 0, 0));
    directed_rows.push_back(row(OP_REMOVE, 2, 0));
    directed_rows.push_back(row_chk(OP_REMOVE, 2, 0, 0, 0, 2, ST_BAD_POS));
    directed_rows.push_back(row(OP_APPEND, 0, -1));
    // duplicate value: lowest position wins
    directed_rows.push_back(row_chk(OP_FIND, 0, -1, 0, 0, 3, ST_OK));
    directed_rows.push_back(row_chk(OP_CLEAR, 0, 0, 0, 0, 0, ST_OK));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_sort_order(1'b0);
    for (k = 0; k < directed_rows.size(); k++) begin
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      write_sort_order(phase_desc[ph]);
      no_gaps = phase_quiet[ph];
      for (k = 0; k < PHASE_ITEMS; k++) begin
        send_item(pick_item(phase_mix[ph]), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_indexed_list_insert_remove_sort_top: PASS");
    end else begin
      $display("tb_indexed_list_insert_remove_sort_top: FAIL");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("tb_indexed_list_insert_remove_sort_top: FAIL");
    $finish;
  end

endmodule
